// File: hw/rtl/fsmcov_pkg.sv
// Shared types and constants for the FSM transition coverage unit.
// Holds the payload structs, mode codes, command and state enums.
// No dependencies.
`timescale 1ns / 1ps

package fsmcov_pkg;

    // Default sizes of the loaded machine.
    localparam int DEF_NUM_STATES         = 64;
    localparam int DEF_NUM_SYMBOLS        = 16;
    localparam int DEF_NUM_TRANSITION_IDS = 1024;

    // Fixed field widths of the transfer payloads.
    localparam int MODE_W     = 2;
    localparam int STATE_W    = 6;
    localparam int SYMBOL_W   = 4;
    localparam int TRANS_ID_W = 10;
    localparam int COUNT_W    = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Mode codes carried by an input transfer.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_APPLY = 2'd2;

    // Width of the coverage epoch tag kept per transition id.
    localparam int EPOCH_W = 8;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [STATE_W-1:0]    from_state;
        logic [SYMBOL_W-1:0]   in_symbol;
        logic [STATE_W-1:0]    to_state;
        logic [TRANS_ID_W-1:0] trans_id;
    } in_item_t;

    typedef struct packed {
        logic [TRANS_ID_W-1:0] taken_id;
        logic                  newly_covered;
        logic                  no_transition;
        logic [COUNT_W-1:0]    covered_count;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_START,
        OP_APPLY
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic                  sym_ok;
        logic [STATE_W-1:0]    from_state;
        logic [SYMBOL_W-1:0]   in_symbol;
        logic [STATE_W-1:0]    to_state;
        logic [TRANS_ID_W-1:0] trans_id;
    } cmd_t;

    typedef struct packed {
        logic                  valid;
        logic [STATE_W-1:0]    next_state;
        logic [TRANS_ID_W-1:0] id;
    } tbl_entry_t;

    typedef enum logic [2:0] {
        BK_INIT_SWEEP,
        BK_WRAP_SWEEP,
        BK_IDLE,
        BK_LOOKUP,
        BK_MARK
    } bk_state_t;

endpackage

// File: hw/rtl/fsmcov_front.sv
// Front end: accepts input transfers, decodes the mode and range-checks loads.
// Pushes surviving commands into the queue. Depends on fsmcov_pkg.
`timescale 1ns / 1ps

module fsmcov_front
    import fsmcov_pkg::*;
#(
    parameter int NUM_STATES         = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS        = DEF_NUM_SYMBOLS,
    parameter int NUM_TRANSITION_IDS = DEF_NUM_TRANSITION_IDS
) (
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     init_done,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic load_ok;
    logic keep;

    assign s_ready = init_done && !q_full;

    always_comb begin
        load_ok = (32'(s_data.from_state) < 32'(NUM_STATES))
               && (32'(s_data.to_state) < 32'(NUM_STATES))
               && (32'(s_data.in_symbol) < 32'(NUM_SYMBOLS))
               && (32'(s_data.trans_id) < 32'(NUM_TRANSITION_IDS));

        q_cmd.sym_ok     = (32'(s_data.in_symbol) < 32'(NUM_SYMBOLS));
        q_cmd.from_state = s_data.from_state;
        q_cmd.in_symbol  = s_data.in_symbol;
        q_cmd.to_state   = s_data.to_state;
        q_cmd.trans_id   = s_data.trans_id;

        case (s_data.mode)
            MODE_LOAD: begin
                q_cmd.op = OP_LOAD;
                keep     = load_ok;
            end
            MODE_START: begin
                q_cmd.op = OP_START;
                keep     = 1'b1;
            end
            MODE_APPLY: begin
                q_cmd.op = OP_APPLY;
                keep     = 1'b1;
            end
            default: begin
                // Unused mode is dropped here.
                q_cmd.op = OP_LOAD;
                keep     = 1'b0;
            end
        endcase
    end

    assign q_push = s_valid && s_ready && keep;

endmodule

// File: hw/rtl/fsmcov_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on fsmcov_pkg for the command type and depth.
`timescale 1ns / 1ps

module fsmcov_queue
    import fsmcov_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty,
    output logic full
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/fsmcov_back.sv
// Back end: transition table, coverage tag memory, walk state and result register.
// Executes queued commands one at a time. Depends on fsmcov_pkg.
`timescale 1ns / 1ps

module fsmcov_back
    import fsmcov_pkg::*;
#(
    parameter int NUM_STATES         = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS        = DEF_NUM_SYMBOLS,
    parameter int NUM_TRANSITION_IDS = DEF_NUM_TRANSITION_IDS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    input  logic [STATE_W-1:0] initial_state,
    output logic               init_done,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data
);

    localparam int ST_AW     = $clog2(NUM_STATES);
    localparam int SYM_AW    = $clog2(NUM_SYMBOLS);
    localparam int TBL_AW    = ST_AW + SYM_AW;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int COV_AW    = $clog2(NUM_TRANSITION_IDS);
    localparam int COV_DEPTH = 1 << COV_AW;
    localparam int SWEEP_W   = (TBL_AW > COV_AW) ? TBL_AW : COV_AW;
    localparam int ST_XW     = (ST_AW > STATE_W) ? ST_AW : STATE_W;
    localparam int SYM_XW    = (SYM_AW > SYMBOL_W) ? SYM_AW : SYMBOL_W;
    localparam int ID_XW     = (COV_AW > TRANS_ID_W) ? COV_AW : TRANS_ID_W;

    // Memories.
    tbl_entry_t         tbl_mem [TBL_DEPTH];
    tbl_entry_t         tbl_rd_reg;
    logic [EPOCH_W-1:0] cov_mem [COV_DEPTH];
    logic [EPOCH_W-1:0] cov_rd_reg;

    // Control and walk state.
    bk_state_t             state_reg;
    bk_state_t             state_next;
    logic [STATE_W-1:0]    cur_state_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [EPOCH_W-1:0]    epoch_reg;
    logic [SWEEP_W-1:0]    sweep_reg;
    logic [TRANS_ID_W-1:0] id_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    // Decoded helpers.
    logic [ST_XW-1:0]   cur_x;
    logic [ST_XW-1:0]   from_x;
    logic [SYM_XW-1:0]  sym_x;
    logic [ID_XW-1:0]   rd_id_x;
    logic [ID_XW-1:0]   held_id_x;
    logic               apply_ok;
    logic               sweep_last;
    logic               out_free;
    logic               fresh;
    logic [COUNT_W-1:0] count_inc;

    // Per-cycle controls.
    logic               tbl_we;
    logic [TBL_AW-1:0]  tbl_waddr;
    tbl_entry_t         tbl_wdata;
    logic               tbl_re;
    logic [TBL_AW-1:0]  tbl_raddr;
    logic               cov_we;
    logic [COV_AW-1:0]  cov_waddr;
    logic [EPOCH_W-1:0] cov_wdata;
    logic               cov_re;
    logic [COV_AW-1:0]  cov_raddr;
    logic               do_start;
    logic               do_step;
    logic               do_count;
    logic               emit;
    out_item_t          emit_data;

    assign cur_x      = ST_XW'(cur_state_reg);
    assign from_x     = ST_XW'(q_cmd.from_state);
    assign sym_x      = SYM_XW'(q_cmd.in_symbol);
    assign rd_id_x    = ID_XW'(tbl_rd_reg.id);
    assign held_id_x  = ID_XW'(id_reg);
    assign apply_ok   = (32'(cur_state_reg) < 32'(NUM_STATES)) && q_cmd.sym_ok;
    assign sweep_last = (sweep_reg == '1);
    assign out_free   = !m_valid_reg || m_ready;
    assign fresh      = (cov_rd_reg != epoch_reg);
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign init_done  = (state_reg != BK_INIT_SWEEP);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_INIT_SWEEP, BK_WRAP_SWEEP: begin
                if (sweep_last) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!q_empty) begin
                    case (q_cmd.op)
                        OP_START: begin
                            if (epoch_reg == '1) begin
                                state_next = BK_WRAP_SWEEP;
                            end
                        end
                        OP_APPLY: begin
                            if (apply_ok) begin
                                state_next = BK_LOOKUP;
                            end
                        end
                        default: begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_LOOKUP: begin
                if (tbl_rd_reg.valid) begin
                    state_next = BK_MARK;
                end else if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            BK_MARK: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        q_pop     = 1'b0;
        tbl_we    = 1'b0;
        tbl_waddr = sweep_reg[TBL_AW-1:0];
        tbl_wdata = '0;
        tbl_re    = 1'b0;
        tbl_raddr = {cur_x[ST_AW-1:0], sym_x[SYM_AW-1:0]};
        cov_we    = 1'b0;
        cov_waddr = sweep_reg[COV_AW-1:0];
        cov_wdata = '0;
        cov_re    = 1'b0;
        cov_raddr = rd_id_x[COV_AW-1:0];
        do_start  = 1'b0;
        do_step   = 1'b0;
        do_count  = 1'b0;
        emit      = 1'b0;
        emit_data.taken_id      = '0;
        emit_data.newly_covered = 1'b0;
        emit_data.no_transition = 1'b1;
        emit_data.covered_count = count_reg;
        case (state_reg)
            BK_INIT_SWEEP: begin
                tbl_we = 1'b1;
                cov_we = 1'b1;
            end
            BK_WRAP_SWEEP: begin
                cov_we = 1'b1;
            end
            BK_IDLE: begin
                if (!q_empty) begin
                    case (q_cmd.op)
                        OP_LOAD: begin
                            q_pop     = 1'b1;
                            tbl_we    = 1'b1;
                            tbl_waddr = {from_x[ST_AW-1:0], sym_x[SYM_AW-1:0]};
                            tbl_wdata.valid      = 1'b1;
                            tbl_wdata.next_state = q_cmd.to_state;
                            tbl_wdata.id         = q_cmd.trans_id;
                        end
                        OP_START: begin
                            q_pop    = 1'b1;
                            do_start = 1'b1;
                        end
                        OP_APPLY: begin
                            if (apply_ok) begin
                                q_pop  = 1'b1;
                                tbl_re = 1'b1;
                            end else if (out_free) begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                            end
                        end
                        default: begin
                            q_pop = 1'b0;
                        end
                    endcase
                end
            end
            BK_LOOKUP: begin
                if (tbl_rd_reg.valid) begin
                    cov_re  = 1'b1;
                    do_step = 1'b1;
                end else if (out_free) begin
                    emit = 1'b1;
                end
            end
            BK_MARK: begin
                if (out_free) begin
                    emit      = 1'b1;
                    cov_waddr = held_id_x[COV_AW-1:0];
                    cov_wdata = epoch_reg;
                    cov_we    = fresh;
                    do_count  = fresh;
                    emit_data.taken_id      = id_reg;
                    emit_data.newly_covered = fresh;
                    emit_data.no_transition = 1'b0;
                    emit_data.covered_count = fresh ? count_inc : count_reg;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_INIT_SWEEP;
            sweep_reg     <= '0;
            cur_state_reg <= '0;
            count_reg     <= '0;
            epoch_reg     <= EPOCH_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == BK_INIT_SWEEP) || (state_reg == BK_WRAP_SWEEP)) begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (do_start) begin
                cur_state_reg <= initial_state;
                count_reg     <= '0;
                epoch_reg     <= (epoch_reg == '1) ? EPOCH_W'(1) : epoch_reg + 1'b1;
            end
            if (do_step) begin
                cur_state_reg <= tbl_rd_reg.next_state;
            end
            if (do_count) begin
                count_reg <= count_inc;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_step) begin
            id_reg <= tbl_rd_reg.id;
        end
        if (emit) begin
            m_data_reg <= emit_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            tbl_rd_reg <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cov_we) begin
            cov_mem[cov_waddr] <= cov_wdata;
        end
        if (cov_re) begin
            cov_rd_reg <= cov_mem[cov_raddr];
        end
    end

endmodule

// File: hw/rtl/fsm_transition_coverage_unit.sv
// FSM transition coverage unit. The back end executes applies one at a time; the queue keeps taking inputs.
// Load and start are done in the idle state; an apply passes the table read, then the tag read.
// An apply that finds no transition skips the tag read.
// Reset: synchronous active-low aresetn; a clearing pass over 2**max(table, id address bits)
// addresses (1024 by default) follows, with s_ready low; the tag pass repeats every 255 starts.
// Depends on fsmcov_pkg, fsmcov_front, fsmcov_queue and fsmcov_back.
`timescale 1ns / 1ps

module fsm_transition_coverage_unit
    import fsmcov_pkg::*;
#(
    parameter int NUM_STATES         = DEF_NUM_STATES,
    parameter int NUM_SYMBOLS        = DEF_NUM_SYMBOLS,
    parameter int NUM_TRANSITION_IDS = DEF_NUM_TRANSITION_IDS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               cfg_wr_en,
    input  logic [STATE_W-1:0] cfg_wr_data
);

    // The initial state register is written directly by the configuration port.
    // It is only sampled when a start command reaches the back end.
    logic [STATE_W-1:0] init_state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_state_reg <= '0;
        end else if (cfg_wr_en) begin
            init_state_reg <= cfg_wr_data;
        end
    end

    // Front to queue.
    logic init_done;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_in_cmd;
    cmd_t q_out_cmd;

    // The front decodes each input transfer and drops the ones that change nothing
    // (the unused mode and out-of-range loads) before they reach the queue.
    fsmcov_front #(
        .NUM_STATES        (NUM_STATES),
        .NUM_SYMBOLS       (NUM_SYMBOLS),
        .NUM_TRANSITION_IDS(NUM_TRANSITION_IDS)
    ) u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .init_done(init_done),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    // The queue lets the front keep taking transfers while the back end waits
    // on a table read or on a result that has not been taken yet.
    fsmcov_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(q_in_cmd),
        .pop     (q_pop),
        .pop_cmd (q_out_cmd),
        .empty   (q_empty),
        .full    (q_full)
    );

    // The back end owns the transition table, the per-id coverage tags and the
    // walk state. Coverage is cleared at a start by bumping an epoch; an id counts
    // as covered when its stored tag equals the current epoch.
    fsmcov_back #(
        .NUM_STATES        (NUM_STATES),
        .NUM_SYMBOLS       (NUM_SYMBOLS),
        .NUM_TRANSITION_IDS(NUM_TRANSITION_IDS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_cmd        (q_out_cmd),
        .q_pop        (q_pop),
        .initial_state(init_state_reg),
        .init_done    (init_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    // No transfer may be taken while the memories are still being cleared.
    a_no_accept_during_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_ready)
        else $error("input transfer possible during clearing pass");

    // The queue must never be pushed while full.
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // A missing transition reports no id and no new coverage.
    a_miss_is_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.no_transition) |->
            ((m_data.taken_id == '0) && !m_data.newly_covered))
        else $error("missing transition result carries coverage data");

    // A newly covered transition implies a nonzero running count.
    a_fresh_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.newly_covered) |-> (m_data.covered_count != '0))
        else $error("new coverage with zero covered count");

endmodule
